[rtl/hdss_pkg.sv]
`default_nettype none

package hdss_pkg;

	// Sizes of the bin store and the fixed-point format.
	localparam int MAX_BINS   = 1024;
	localparam int FRAC_BITS  = 16;
	localparam int COUNT_BITS = 24;
	localparam int ADDR_BITS  = $clog2(MAX_BINS);
	localparam int NBIN_BITS  = ADDR_BITS + 1;
	localparam int DT_BITS    = 16;
	localparam int STEP_BITS  = 17;
	localparam int OP_BITS    = 2;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 16;

	localparam int VAL_BITS = COUNT_BITS + FRAC_BITS;
	localparam int D1_BITS  = VAL_BITS + 1;
	localparam int D2_BITS  = VAL_BITS + 2;

	// Diffusion arithmetic widths. The second difference is split in two halves
	// so that each partial product stays a narrow multiplier.
	localparam int X_BITS    = VAL_BITS + 2;
	localparam int XL_BITS   = X_BITS / 2;
	localparam int XH_BITS   = X_BITS - XL_BITS;
	localparam int PL_BITS   = DT_BITS + XL_BITS;
	localparam int PH_BITS   = DT_BITS + 1 + XH_BITS;
	localparam int PROD_BITS = X_BITS + DT_BITS + 1;
	localparam int TERM_BITS = X_BITS + 1;
	localparam int SUM_BITS  = TERM_BITS + 1;

	// Stream payload widths, rounded up to whole bytes.
	localparam int IN_FIELD_BITS  = ADDR_BITS + COUNT_BITS + STEP_BITS;
	localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = VAL_BITS + D1_BITS + D2_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

	// Reset values of the configuration registers.
	localparam logic [DT_BITS-1:0]   DT_RESET   = DT_BITS'(8192);
	localparam logic [NBIN_BITS-1:0] BINS_RESET = NBIN_BITS'(MAX_BINS);

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIFFUSION_STEP = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BINS_IN_USE    = 1'b1;

	typedef enum logic [OP_BITS-1:0] {
		OP_LOAD = 2'd0,
		OP_RUN  = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CAP_NONE,
		CAP_LEFT,
		CAP_MID,
		CAP_RIGHT
	} cap_t;

	typedef enum logic [1:0] {
		RK_EMPTY,
		RK_LOAD,
		RK_READ
	} res_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SWEEP,
		ST_DRAIN,
		ST_RD_LEFT,
		ST_RD_MID,
		ST_RD_RIGHT,
		ST_RD_WAIT,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                 take;
		logic                 rd_en;
		logic [ADDR_BITS-1:0] rd_addr;
		logic                 ld_en;
		logic [ADDR_BITS-1:0] ld_addr;
		logic                 shift;
		logic                 compute;
		logic                 first;
		logic                 last;
		logic [ADDR_BITS-1:0] wr_addr;
		cap_t                 cap;
		logic                 res_en;
		res_kind_t            res_kind;
		logic                 res_status;
		logic                 interior;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

[rtl/histogram_diffusion_scale_space.sv]
`default_nettype none

// Histogram scale space by explicit 1-D heat diffusion.
// Items enter on the s_axis stream: tuser carries the operation (load, run,
// read) and tdata the bin index, the count to load and the number of steps.
// Every item produces one transfer on the m_axis stream with the smoothed
// bin value, the doubled central difference, the second difference and an
// error flag in tuser. Two configuration registers (time step, bins in use)
// are written through cfg_we/cfg_index/cfg_data. The user must write them
// only while the block is idle; the block itself does not enforce this.
// A load decodes the item and writes the bin, then registers its result.
// A read decodes, makes three reads of the bin and its neighbors through the
// single read port of the bin memory, captures the last read data, then
// registers the result. A run streams, for each step, every bin in use once
// through the read port, then drains the four-stage update pipeline before
// the next step starts.
// One item is processed at a time; s_axis_tready is high only while idle,
// so the next transfer is accepted only once the result is registered.
// Reset clears the controller, the output valid and the configuration;
// the bin memory keeps no reset and must be loaded before use.
// When the receiver stalls, the result holds in the output register and
// the block waits before finishing the next item.
module histogram_diffusion_scale_space
	import hdss_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	// bin_index, bin_count, step_count, zero fill
	input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
	// operation
	input  wire logic [OP_BITS-1:0]        s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	// smoothed_value, first_difference_doubled, second_difference, zero fill
	output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata,
	// status
	output logic                           m_axis_tuser,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

	logic [DT_BITS-1:0]   dt_q;
	logic [NBIN_BITS-1:0] bins_q;
	logic [NBIN_BITS-1:0] n_bins;

	logic [ADDR_BITS-1:0]  bin_index;
	logic [COUNT_BITS-1:0] bin_count;
	logic [STEP_BITS-1:0]  step_count;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	logic [VAL_BITS-1:0] out_value;
	logic [D1_BITS-1:0]  out_d1;
	logic [D2_BITS-1:0]  out_d2;

	assign bin_index  = s_axis_tdata[ADDR_BITS-1:0];
	assign bin_count  = s_axis_tdata[ADDR_BITS +: COUNT_BITS];
	assign step_count = s_axis_tdata[ADDR_BITS + COUNT_BITS +: STEP_BITS];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q   <= DT_RESET;
			bins_q <= BINS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIFFUSION_STEP: dt_q   <= cfg_data[DT_BITS-1:0];
				CFG_BINS_IN_USE:    bins_q <= cfg_data[NBIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Effective bin count, held between two and the store depth.
	always_comb begin
		if (bins_q < NBIN_BITS'(2)) begin
			n_bins = NBIN_BITS'(2);
		end else if (bins_q > NBIN_BITS'(MAX_BINS)) begin
			n_bins = NBIN_BITS'(MAX_BINS);
		end else begin
			n_bins = bins_q;
		end
	end

	hdss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.operation  (s_axis_tuser),
		.bin_index  (bin_index),
		.step_count (step_count),
		.n_bins     (n_bins),
		.stat       (stat),
		.cmd        (cmd)
	);

	hdss_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.dt         (dt_q),
		.bin_count  (bin_count),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_value  (out_value),
		.out_d1     (out_d1),
		.out_d2     (out_d2),
		.out_status (m_axis_tuser)
	);

	assign m_axis_tdata = {{(OUT_TDATA_BITS - OUT_FIELD_BITS){1'b0}}, out_d2, out_d1, out_value};

endmodule

`default_nettype wire

[rtl/hdss_datapath.sv]
`default_nettype none

module hdss_datapath
	import hdss_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dp_cmd_t                cmd,
	input  wire logic [DT_BITS-1:0]     dt,
	input  wire logic [COUNT_BITS-1:0]  bin_count,
	output dp_stat_t                    stat,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [VAL_BITS-1:0]         out_value,
	output logic [D1_BITS-1:0]          out_d1,
	output logic [D2_BITS-1:0]          out_d2,
	output logic                        out_status
);

	logic [VAL_BITS-1:0] bin_mem [MAX_BINS];

	logic [COUNT_BITS-1:0] count_q;
	logic [VAL_BITS-1:0]   load_value;

	logic [VAL_BITS-1:0]   rd_data_s1;
	logic                  shift_s1, comp_s1, first_s1, last_s1;
	logic [ADDR_BITS-1:0]  waddr_s1;
	cap_t                  cap_s1;

	logic [VAL_BITS-1:0]   prev1_q, prev2_q;
	logic [VAL_BITS-1:0]   left_q, mid_q, right_q;

	logic                  comp_s2, first_s2;
	logic [ADDR_BITS-1:0]  waddr_s2;
	logic [VAL_BITS-1:0]   v_s2;
	logic signed [X_BITS-1:0] x_s2;

	logic                  comp_s3, first_s3;
	logic [ADDR_BITS-1:0]  waddr_s3;
	logic [VAL_BITS-1:0]   v_s3;
	logic [PL_BITS-1:0]    pl_s3;
	logic signed [PH_BITS-1:0] ph_s3;

	logic                  comp_s4;
	logic [ADDR_BITS-1:0]  waddr_s4;
	logic [VAL_BITS-1:0]   v_s4;
	logic signed [TERM_BITS-1:0] term_s4;

	logic signed [X_BITS-1:0]    x_s1;
	logic [VAL_BITS-1:0]         l_s1, r_s1;
	logic [XL_BITS-1:0]          xl_s2;
	logic signed [XH_BITS-1:0]   xh_s2;
	logic [PL_BITS-1:0]          pl_s2;
	logic signed [PH_BITS-1:0]   ph_s2;
	logic signed [PROD_BITS-1:0] prod_s3, prod_sh_s3;
	logic signed [TERM_BITS-1:0] term_s3;
	logic signed [SUM_BITS-1:0]  sum_s4;
	logic [VAL_BITS-1:0]         new_s4;

	logic                  out_valid_q;
	logic [VAL_BITS-1:0]   out_value_q;
	logic [D1_BITS-1:0]    out_d1_q;
	logic [D2_BITS-1:0]    out_d2_q;
	logic                  out_status_q;
	logic [D1_BITS-1:0]    rd_d1;
	logic [D2_BITS-1:0]    rd_d2;

	assign load_value = {count_q, {FRAC_BITS{1'b0}}};

	// Item payload latch.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			count_q <= bin_count;
		end
	end

	// Bin memory: one write port shared by loads and the diffusion writeback,
	// one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.ld_en) begin
			bin_mem[cmd.ld_addr] <= load_value;
		end else if (comp_s4) begin
			bin_mem[waddr_s4] <= new_s4;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= bin_mem[cmd.rd_addr];
		end
	end

	// Second difference of the bin whose right neighbor just arrived.
	always_comb begin
		l_s1 = first_s1 ? '0 : prev2_q;
		r_s1 = last_s1 ? '0 : rd_data_s1;
		x_s1 = $signed({2'b00, l_s1}) + $signed({2'b00, r_s1})
			- $signed({1'b0, prev1_q, 1'b0});
	end

	// Two partial products of dt and the second difference.
	always_comb begin
		xl_s2 = x_s2[XL_BITS-1:0];
		xh_s2 = x_s2[X_BITS-1:XL_BITS];
		pl_s2 = PL_BITS'(dt) * PL_BITS'(xl_s2);
		ph_s2 = $signed({1'b0, dt}) * xh_s2;
	end

	// Full product, then the floor shift: the first bin takes the full dt.
	always_comb begin
		prod_s3 = (PROD_BITS'(ph_s3) <<< XL_BITS) + PROD_BITS'($signed({1'b0, pl_s3}));
		prod_sh_s3 = first_s3 ? (prod_s3 >>> DT_BITS) : (prod_s3 >>> (DT_BITS + 1));
		term_s3 = prod_sh_s3[TERM_BITS-1:0];
	end

	// Update and clamp at zero.
	always_comb begin
		sum_s4 = SUM_BITS'($signed({1'b0, v_s4})) + SUM_BITS'(term_s4);
		new_s4 = sum_s4[SUM_BITS-1] ? '0 : sum_s4[VAL_BITS-1:0];
	end

	// Pipeline control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_s1 <= 1'b0;
			comp_s1  <= 1'b0;
			cap_s1   <= CAP_NONE;
			comp_s2  <= 1'b0;
			comp_s3  <= 1'b0;
			comp_s4  <= 1'b0;
		end else begin
			shift_s1 <= cmd.shift;
			comp_s1  <= cmd.compute;
			cap_s1   <= cmd.cap;
			comp_s2  <= comp_s1;
			comp_s3  <= comp_s2;
			comp_s4  <= comp_s3;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		waddr_s1 <= cmd.wr_addr;
		if (shift_s1) begin
			prev2_q <= prev1_q;
			prev1_q <= rd_data_s1;
		end
		first_s2 <= first_s1;
		waddr_s2 <= waddr_s1;
		v_s2     <= prev1_q;
		x_s2     <= x_s1;
		first_s3 <= first_s2;
		waddr_s3 <= waddr_s2;
		v_s3     <= v_s2;
		pl_s3    <= pl_s2;
		ph_s3    <= ph_s2;
		waddr_s4 <= waddr_s3;
		v_s4     <= v_s3;
		term_s4  <= term_s3;
	end

	// Neighborhood capture for a read.
	always_ff @(posedge clk) begin
		case (cap_s1)
			CAP_LEFT:  left_q  <= rd_data_s1;
			CAP_MID:   mid_q   <= rd_data_s1;
			CAP_RIGHT: right_q <= rd_data_s1;
			default: ;
		endcase
	end

	always_comb begin
		rd_d1 = '0;
		rd_d2 = '0;
		if (cmd.interior) begin
			rd_d1 = {1'b0, right_q} - {1'b0, left_q};
			rd_d2 = {2'b00, left_q} + {2'b00, right_q} - {1'b0, mid_q, 1'b0};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_en) begin
			out_status_q <= cmd.res_status;
			case (cmd.res_kind)
				RK_LOAD: begin
					out_value_q <= load_value;
					out_d1_q    <= '0;
					out_d2_q    <= '0;
				end
				RK_READ: begin
					out_value_q <= mid_q;
					out_d1_q    <= rd_d1;
					out_d2_q    <= rd_d2;
				end
				default: begin
					out_value_q <= '0;
					out_d1_q    <= '0;
					out_d2_q    <= '0;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_d1     = out_d1_q;
	assign out_d2     = out_d2_q;
	assign out_status = out_status_q;

	assign stat.busy     = shift_s1 | comp_s1 | comp_s2 | comp_s3 | comp_s4;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

`default_nettype wire

[rtl/hdss_ctrl.sv]
`default_nettype none

module hdss_ctrl
	import hdss_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [OP_BITS-1:0]    operation,
	input  wire logic [ADDR_BITS-1:0]  bin_index,
	input  wire logic [STEP_BITS-1:0]  step_count,
	input  wire logic [NBIN_BITS-1:0]  n_bins,
	input  wire dp_stat_t              stat,
	output dp_cmd_t                    cmd
);

	state_t               state_q, state_d;
	op_t                  op_q;
	logic [ADDR_BITS-1:0] idx_q;
	logic [STEP_BITS-1:0] steps_q;
	logic [NBIN_BITS-1:0] slot_q;
	res_kind_t            kind_q, dec_kind;
	logic                 status_q, dec_status;
	logic                 interior_q;

	logic idx_ok, interior, take;

	assign take     = (state_q == ST_IDLE) && in_valid;
	assign idx_ok   = {1'b0, idx_q} < n_bins;
	assign interior = (idx_q != '0) && (({1'b0, idx_q} + 1'b1) < n_bins);

	// Result kind decided from the latched item.
	always_comb begin
		case (op_q)
			OP_LOAD: begin
				dec_kind   = idx_ok ? RK_LOAD : RK_EMPTY;
				dec_status = !idx_ok;
			end
			OP_RUN: begin
				dec_kind   = RK_EMPTY;
				dec_status = 1'b0;
			end
			OP_READ: begin
				dec_kind   = idx_ok ? RK_READ : RK_EMPTY;
				dec_status = !idx_ok;
			end
			default: begin
				dec_kind   = RK_EMPTY;
				dec_status = 1'b1;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (op_q)
					OP_RUN:  state_d = (steps_q == '0) ? ST_RESP : ST_SWEEP;
					OP_READ: state_d = idx_ok ? ST_RD_LEFT : ST_RESP;
					default: state_d = ST_RESP;
				endcase
			end
			ST_SWEEP: begin
				if (slot_q == n_bins) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.busy) state_d = (steps_q == STEP_BITS'(1)) ? ST_RESP : ST_SWEEP;
			end
			ST_RD_LEFT:  state_d = ST_RD_MID;
			ST_RD_MID:   state_d = ST_RD_RIGHT;
			ST_RD_RIGHT: state_d = ST_RD_WAIT;
			ST_RD_WAIT:  state_d = ST_RESP;
			ST_RESP: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands for the datapath.
	always_comb begin
		cmd            = '0;
		cmd.cap        = CAP_NONE;
		cmd.res_kind   = kind_q;
		cmd.res_status = status_q;
		cmd.interior   = interior_q;
		cmd.take       = take;
		in_ready       = (state_q == ST_IDLE);
		case (state_q)
			ST_DECODE: begin
				cmd.ld_en   = (op_q == OP_LOAD) && idx_ok;
				cmd.ld_addr = idx_q;
			end
			ST_SWEEP: begin
				cmd.rd_en   = slot_q < n_bins;
				cmd.rd_addr = slot_q[ADDR_BITS-1:0];
				cmd.shift   = slot_q < n_bins;
				cmd.compute = slot_q != '0;
				cmd.first   = slot_q == NBIN_BITS'(1);
				cmd.last    = slot_q == n_bins;
				cmd.wr_addr = slot_q[ADDR_BITS-1:0] - 1'b1;
			end
			ST_RD_LEFT: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = idx_q - 1'b1;
				cmd.cap     = CAP_LEFT;
			end
			ST_RD_MID: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = idx_q;
				cmd.cap     = CAP_MID;
			end
			ST_RD_RIGHT: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_addr = idx_q + 1'b1;
				cmd.cap     = CAP_RIGHT;
			end
			ST_RESP: begin
				cmd.res_en = stat.out_free;
			end
			default: ;
		endcase
	end

	// Controller registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_LOAD;
			idx_q      <= '0;
			steps_q    <= '0;
			slot_q     <= '0;
			kind_q     <= RK_EMPTY;
			status_q   <= 1'b0;
			interior_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						op_q    <= op_t'(operation);
						idx_q   <= bin_index;
						steps_q <= step_count;
					end
				end
				ST_DECODE: begin
					kind_q     <= dec_kind;
					status_q   <= dec_status;
					interior_q <= interior;
					slot_q     <= '0;
				end
				ST_SWEEP: begin
					slot_q <= slot_q + 1'b1;
				end
				ST_DRAIN: begin
					if (!stat.busy) begin
						steps_q <= steps_q - 1'b1;
						slot_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire
